// File: sv/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants for the linear probing hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package lpht_pkg;

    localparam int SLOTS      = 64;
    localparam int KEY_BYTES  = 8;
    localparam int VALUE_BITS = 32;

    localparam int IDX_W    = $clog2(SLOTS);
    localparam int KEY_W    = 64;
    localparam int VAL_W    = 32;
    localparam int OCC_W    = 7;
    localparam int HANDLE_W = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
    localparam int MARK_W   = 2;
    localparam int ENTRY_W  = MARK_W + HANDLE_W + KEY_W;
    localparam int SUM_W    = 11;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_DELETE = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        MARK_EMPTY = 2'd0,
        MARK_LIVE  = 2'd1,
        MARK_TOMB  = 2'd2
    } t_mark;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK,
        S_RESULT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic    load;
        logic    hash;
        logic    step;
        logic    write;
        logic    wr_tomb;
        logic    inc;
        logic    dec;
        logic    set_res;
        t_status res_status;
        logic    res_found;
        logic    res_repl;
        logic    res_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        t_mark      mark;
        logic       key_match;
        logic       last_probe;
        logic       out_busy;
    } t_dp_stat;

    // canonical key: bytes from the first zero byte upward are cleared
    function automatic logic [KEY_W-1:0] canon_key(input logic [KEY_W-1:0] raw);
        logic [KEY_W-1:0] res;
        logic             keep;
        res  = '0;
        keep = 1'b1;
        for (int i = 0; i < 8; i++) begin
            keep = keep && (i < KEY_BYTES) && (raw[8*i +: 8] != 8'd0);
            if (keep) begin
                res[8*i +: 8] = raw[8*i +: 8];
            end
        end
        return res;
    endfunction

    function automatic logic [IDX_W-1:0] home_slot(input logic [KEY_W-1:0] k);
        logic [SUM_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < 8; i++) begin
            sum = sum + SUM_W'(k[8*i +: 8]);
        end
        return IDX_W'(sum % SLOTS);
    endfunction

endpackage

`default_nettype wire

// File: sv/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// File: sv/lpht_ctrl.sv
// ----------------------------------------------------------------------------
// lpht_ctrl
// Sequencer for one table operation: hash, probe loop and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_ctrl
    import lpht_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.res_status = ST_NOT_FOUND;
        o_in_ready = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_HASH;
                end
            end

            S_HASH: begin
                o_cmd.hash = 1'b1;
                case (i_stat.op)
                    OP_INSERT, OP_LOOKUP, OP_DELETE: begin
                        n_state = S_READ;
                    end
                    default: begin
                        // unused op code: no change, not found
                        o_cmd.set_res    = 1'b1;
                        o_cmd.res_status = ST_NOT_FOUND;
                        n_state          = S_RESULT;
                    end
                endcase
            end

            S_READ: begin
                n_state = S_CHECK;
            end

            S_CHECK: begin
                if (i_stat.op == OP_INSERT) begin
                    if (i_stat.mark != MARK_LIVE) begin
                        o_cmd.write      = 1'b1;
                        o_cmd.inc        = 1'b1;
                        o_cmd.set_res    = 1'b1;
                        o_cmd.res_status = ST_OK;
                        n_state          = S_RESULT;
                    end else if (i_stat.key_match) begin
                        o_cmd.write      = 1'b1;
                        o_cmd.set_res    = 1'b1;
                        o_cmd.res_status = ST_OK;
                        o_cmd.res_repl   = 1'b1;
                        n_state          = S_RESULT;
                    end else if (i_stat.last_probe) begin
                        o_cmd.set_res    = 1'b1;
                        o_cmd.res_status = ST_FULL;
                        n_state          = S_RESULT;
                    end else begin
                        o_cmd.step = 1'b1;
                        n_state    = S_READ;
                    end
                end else begin
                    if (i_stat.mark == MARK_EMPTY) begin
                        o_cmd.set_res    = 1'b1;
                        o_cmd.res_status = ST_NOT_FOUND;
                        n_state          = S_RESULT;
                    end else if (i_stat.key_match) begin
                        o_cmd.set_res = 1'b1;
                        n_state       = S_RESULT;
                        if (i_stat.mark == MARK_LIVE) begin
                            o_cmd.res_status = ST_OK;
                            if (i_stat.op == OP_LOOKUP) begin
                                o_cmd.res_found = 1'b1;
                            end else begin
                                o_cmd.write   = 1'b1;
                                o_cmd.wr_tomb = 1'b1;
                                o_cmd.dec     = 1'b1;
                            end
                        end else begin
                            // tombstone with the same key ends the search
                            o_cmd.res_status = ST_NOT_FOUND;
                        end
                    end else if (i_stat.last_probe) begin
                        o_cmd.set_res    = 1'b1;
                        o_cmd.res_status = ST_NOT_FOUND;
                        n_state          = S_RESULT;
                    end else begin
                        o_cmd.step = 1'b1;
                        n_state    = S_READ;
                    end
                end
            end

            S_RESULT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/lpht_dp.sv
// ----------------------------------------------------------------------------
// lpht_dp
// Datapath: operand registers, probe index, slot memory with valid bits,
// live counter and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_dp
    import lpht_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [1:0]       i_op,
    input  wire logic [KEY_W-1:0] i_key,
    input  wire logic [VAL_W-1:0] i_value,
    input  wire t_dp_cmd          i_cmd,
    output t_dp_stat              o_stat,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [1:0]            o_status,
    output logic [VAL_W-1:0]      o_found_value,
    output logic                  o_replaced,
    output logic [OCC_W-1:0]      o_occupancy
);

    logic [1:0]          r_op;
    logic [KEY_W-1:0]    r_key;
    logic [HANDLE_W-1:0] r_value;
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    r_cnt;
    logic [OCC_W-1:0]    r_live;
    logic [SLOTS-1:0]    r_slot_vld;
    logic                r_rd_vld;

    t_status             r_res_status;
    logic [VAL_W-1:0]    r_res_found;
    logic                r_res_repl;
    logic                r_out_valid;

    logic [ENTRY_W-1:0]  rd_data;
    logic [ENTRY_W-1:0]  wr_data;
    logic [KEY_W-1:0]    rd_key;
    logic [HANDLE_W-1:0] rd_handle;
    t_mark               rd_mark;

    assign rd_key    = rd_data[KEY_W-1:0];
    assign rd_handle = rd_data[KEY_W +: HANDLE_W];
    // slots never written read as empty
    assign rd_mark   = r_rd_vld ? t_mark'(rd_data[ENTRY_W-1 -: MARK_W]) : MARK_EMPTY;

    assign wr_data = i_cmd.wr_tomb ? {MARK_TOMB, rd_handle, r_key}
                                   : {MARK_LIVE, r_value, r_key};

    lpht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_we      (i_cmd.write),
        .i_wr_addr (r_idx),
        .i_wr_data (wr_data),
        .i_rd_addr (r_idx),
        .o_rd_data (rd_data)
    );

    // operand and probe registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_key   <= i_key;
            r_value <= HANDLE_W'(i_value);
        end
        if (i_cmd.hash) begin
            r_key <= canon_key(r_key);
            r_idx <= home_slot(canon_key(r_key));
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            r_idx <= (r_idx == IDX_W'(SLOTS - 1)) ? '0 : r_idx + 1'b1;
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.set_res) begin
            r_res_status <= i_cmd.res_status;
            r_res_found  <= i_cmd.res_found ? VAL_W'(rd_handle) : '0;
            r_res_repl   <= i_cmd.res_repl;
        end
        if (i_cmd.res_load) begin
            o_status      <= r_res_status;
            o_found_value <= r_res_found;
            o_replaced    <= r_res_repl;
            o_occupancy   <= r_live;
        end
    end

    // valid bits and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_vld  <= '0;
            r_rd_vld    <= 1'b0;
            r_live      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= r_slot_vld[r_idx];
            if (i_cmd.write) begin
                r_slot_vld[r_idx] <= 1'b1;
            end
            if (i_cmd.inc) begin
                r_live <= r_live + 1'b1;
            end else if (i_cmd.dec && (r_live != '0)) begin
                r_live <= r_live - 1'b1;
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_stat.op         = r_op;
    assign o_stat.mark       = rd_mark;
    assign o_stat.key_match  = (rd_key == r_key);
    assign o_stat.last_probe = (r_cnt == IDX_W'(SLOTS - 1));
    assign o_stat.out_busy   = r_out_valid && !i_out_ready;

endmodule

`default_nettype wire

// File: sv/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with linear probing over a fixed slot count.
// ----------------------------------------------------------------------------
//  channel | direction | tdata (lowest bit up)                 | tuser
//  s_axis  | in        | key[63:0] value[95:64]                | op[1:0]
//  m_axis  | out       | status[1:0] found_value[33:2]         | -
//          |           | replaced_existing[34] occupancy[41:35]|
//
//  after acceptance the controller steps through S_HASH, then S_READ and S_CHECK
//  for each of the p slots probed (1 to 64, none for the unused op code), then
//  S_RESULT; each probe is a registered read of the slot ram followed by a compare.
//  s_axis_tready rises again in the cycle after the result is loaded.
//  reset clears the slot valid bits and live count at once; no clearing pass.
//  s_axis_tready is high only between operations; a finished result waits in
//  the output register while the next transaction is accepted, and a second
//  finished result waits in the datapath result registers with s_axis_tready low.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_probe_hash_table
    import lpht_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [95:0]  s_axis_tdata,   // key[63:0], value[95:64]
    input  wire logic [1:0]   s_axis_tuser,   // op[1:0]
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [47:0]       m_axis_tdata    // status, found_value, replaced, occupancy, pad
);

    t_dp_cmd          cmd;
    t_dp_stat         stat;
    logic [1:0]       status;
    logic [VAL_W-1:0] found_value;
    logic             replaced;
    logic [OCC_W-1:0] occupancy;

    lpht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lpht_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (s_axis_tuser),
        .i_key         (s_axis_tdata[KEY_W-1:0]),
        .i_value       (s_axis_tdata[KEY_W +: VAL_W]),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_status      (status),
        .o_found_value (found_value),
        .o_replaced    (replaced),
        .o_occupancy   (occupancy)
    );

    assign m_axis_tdata = {6'd0, occupancy, replaced, found_value, status};

endmodule

`default_nettype wire

// File: verif/hash_table_mirror_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hash_table_mirror_pkg
// Scoreboard for the linear probing hash table. It keeps its own slot array
// and live count, queues the reply each accepted transaction should give and
// compares every returned reply with the oldest one queued.
// ----------------------------------------------------------------------------
package hash_table_mirror_pkg;

    import lpht_pkg::*;

    localparam logic [31:0] HANDLE_MASK = 32'((64'd1 << VALUE_BITS) - 64'd1);

    typedef struct {
        t_status     status;
        logic [31:0] found_value;
        logic        replaced;
        logic [6:0]  occupancy;
    } t_reply;

    class hash_table_mirror;
        logic [KEY_W-1:0] slot_key [SLOTS];
        logic [31:0]      slot_handle [SLOTS];
        t_mark            slot_mark [SLOTS];
        int unsigned      live;
        int unsigned      errors;
        int unsigned      checked;
        t_reply           pending_replies [$];

        function new();
            foreach (slot_mark[i]) begin
                slot_mark[i] = MARK_EMPTY;
            end
            live    = 0;
            errors  = 0;
            checked = 0;
        endfunction

        function int unsigned pending();
            return pending_replies.size();
        endfunction

        // bytes from the first zero byte upward do not belong to the key
        static function logic [KEY_W-1:0] trim_key(logic [KEY_W-1:0] raw);
            int n;
            n = 0;
            while (n < KEY_BYTES && raw[8*n +: 8] != 8'd0) begin
                n++;
            end
            if (n == 8) begin
                return raw;
            end
            return raw & ((64'd1 << (8 * n)) - 64'd1);
        endfunction

        function void note_request(logic [1:0] op, logic [KEY_W-1:0] raw_key,
                                   logic [31:0] value);
            logic [KEY_W-1:0] k;
            int unsigned      idx;
            int unsigned      byte_total;
            t_reply           r;
            k = trim_key(raw_key);
            byte_total = 0;
            for (int i = 0; i < 8; i++) begin
                byte_total += k[8*i +: 8];
            end
            idx           = byte_total % SLOTS;
            r.status      = ST_NOT_FOUND;
            r.found_value = '0;
            r.replaced    = 1'b0;
            case (op)
                OP_INSERT: begin
                    r.status = ST_FULL;
                    for (int n = 0; n < SLOTS; n++) begin
                        // any slot that is not live is taken, tombstones too
                        if (slot_mark[idx] != MARK_LIVE) begin
                            slot_key[idx]    = k;
                            slot_handle[idx] = value & HANDLE_MASK;
                            slot_mark[idx]   = MARK_LIVE;
                            live++;
                            r.status = ST_OK;
                            break;
                        end
                        if (slot_key[idx] == k) begin
                            slot_handle[idx] = value & HANDLE_MASK;
                            r.replaced = 1'b1;
                            r.status   = ST_OK;
                            break;
                        end
                        idx = (idx + 1) % SLOTS;
                    end
                end
                OP_LOOKUP, OP_DELETE: begin
                    for (int n = 0; n < SLOTS; n++) begin
                        if (slot_mark[idx] == MARK_EMPTY) begin
                            break;
                        end
                        // a tombstone with the same key also ends the search
                        if (slot_key[idx] == k) begin
                            if (slot_mark[idx] == MARK_LIVE) begin
                                r.status = ST_OK;
                                if (op == OP_LOOKUP) begin
                                    r.found_value = slot_handle[idx];
                                end else begin
                                    slot_mark[idx] = MARK_TOMB;
                                    live--;
                                end
                            end
                            break;
                        end
                        idx = (idx + 1) % SLOTS;
                    end
                end
                default: begin
                end
            endcase
            r.occupancy = 7'(live);
            pending_replies.push_back(r);
        endfunction

        function void check_reply(logic [47:0] tdata);
            t_reply      exp_r;
            logic [1:0]  got_status;
            logic [31:0] got_found;
            logic        got_repl;
            logic [6:0]  got_occ;
            got_status = tdata[1:0];
            got_found  = tdata[33:2];
            got_repl   = tdata[34];
            got_occ    = tdata[41:35];
            if (pending_replies.size() == 0) begin
                $error("reply with nothing outstanding: tdata %h", tdata);
                errors++;
                return;
            end
            exp_r = pending_replies.pop_front();
            checked++;
            if (got_status != exp_r.status) begin
                $error("status: expected %0d, got %0d", exp_r.status, got_status);
                errors++;
            end
            if (got_found != exp_r.found_value) begin
                $error("found_value: expected %h, got %h", exp_r.found_value, got_found);
                errors++;
            end
            if (got_repl != exp_r.replaced) begin
                $error("replaced_existing: expected %0d, got %0d", exp_r.replaced, got_repl);
                errors++;
            end
            if (got_occ != exp_r.occupancy) begin
                $error("occupancy: expected %0d, got %0d", exp_r.occupancy, got_occ);
                errors++;
            end
        endfunction
    endclass

endpackage

// File: verif/linear_probe_hash_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_test
// Drives insert, lookup and delete transactions into the hash table, first a
// directed set around aliasing, tombstones and wrap-around, then random
// traffic over colliding keys, a fill to capacity and a mass delete. Replies
// are checked field by field against the scoreboard's own table.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_test;

    import lpht_pkg::*;
    import hash_table_mirror_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         TARGET_OPS  = 650;
    localparam int         QUIET_TAIL  = 150;
    localparam int         HOLD_CYCLES = 300;
    localparam int         DRAIN_TAIL  = 150;
    localparam int         STALL_LIMIT = 3000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;   // key[63:0], value[95:64]
    logic [1:0]  s_axis_tuser;   // op[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // status, found_value, replaced, occupancy, pad

    hash_table_mirror mirror;
    logic [63:0]      key_pool [$];
    int unsigned      ops_sent;
    int unsigned      quiet_cycles;
    int unsigned      tx_idle_pct;
    int unsigned      rx_idle_pct;
    bit               hold_req;

    linear_probe_hash_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // two-byte key whose byte sum lands on the given home slot
    function automatic logic [63:0] key_with_home(int unsigned home);
        logic [7:0]  a;
        logic [7:0]  b;
        logic [63:0] k;
        a = 8'($urandom_range(1, 255));
        b = 8'(((home + 256 - a) % 64) + 64 * $urandom_range(0, 3));
        if (b == 8'd0) begin
            b = 8'd64;
        end
        k = {48'd0, b, a};
        // stray bytes above the terminating zero must not change the key
        if ($urandom_range(0, 1) == 1) begin
            k[63:24] = 40'({$urandom, $urandom});
        end
        return k;
    endfunction

    function automatic logic [63:0] scatter_key();
        int unsigned len;
        logic [63:0] k;
        len = $urandom_range(1, 8);
        k   = {$urandom, $urandom};
        for (int i = 0; i < 8; i++) begin
            if (i < len) begin
                if (k[8*i +: 8] == 8'd0) begin
                    k[8*i +: 8] = 8'd1;
                end
            end else if (i == len || $urandom_range(0, 1) == 0) begin
                k[8*i +: 8] = 8'd0;
            end
        end
        return k;
    endfunction

    task automatic push_op(input logic [1:0] op, input logic [63:0] key,
                           input logic [31:0] value);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {value, key};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        mirror.note_request(op, key, value);
        ops_sent++;
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic random_op();
        int unsigned r;
        logic [1:0]  op;
        logic [63:0] k;
        logic [31:0] v;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            op = OP_INSERT;
        end else if (r < 74) begin
            op = OP_LOOKUP;
        end else if (r < 97) begin
            op = OP_DELETE;
        end else begin
            op = OP_UNUSED;
        end
        if ($urandom_range(0, 9) == 0) begin
            k = {$urandom, $urandom};
        end else begin
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end
        case ($urandom_range(0, 9))
            0: v = 32'd0;
            1: v = 32'hffff_ffff;
            default: v = $urandom;
        endcase
        push_op(op, k, v);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (mirror.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // receiver: short random stalls, plus one long hold-off on request
    initial begin
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // reply checking and stall watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                mirror.check_reply(m_axis_tdata);
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("linear_probe_hash_table_test: errors");
                $finish;
            end
        end
    end

    initial begin
        logic [63:0] fresh;
        logic [63:0] fill_keys [$];
        mirror       = new();
        ops_sent     = 0;
        quiet_cycles = 0;
        hold_req     = 1'b0;
        tx_idle_pct  = 20;
        rx_idle_pct  = 20;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // two tight clusters, one of them wrapping past the last slot
        repeat (16) key_pool.push_back(key_with_home(7));
        repeat (10) key_pool.push_back(key_with_home(62));
        repeat (14) key_pool.push_back(scatter_key());

        // directed: empty table, extremes, aliasing, tombstones, wrap-around
        push_op(OP_LOOKUP, 64'h41, $urandom);
        push_op(OP_DELETE, 64'h41, $urandom);
        push_op(OP_INSERT, 64'h0, 32'h0);
        push_op(OP_LOOKUP, 64'h0, $urandom);
        push_op(OP_INSERT, '1, 32'hffff_ffff);
        push_op(OP_LOOKUP, '1, $urandom);
        push_op(OP_INSERT, '1, 32'h1234_5678);
        push_op(OP_INSERT, 64'hdead_beef_ca00_0041, 32'ha5a5_0001);
        push_op(OP_LOOKUP, 64'h41, $urandom);
        push_op(OP_UNUSED, 64'h41, $urandom);
        push_op(OP_DELETE, 64'h41, $urandom);
        push_op(OP_DELETE, 64'h41, $urandom);
        push_op(OP_LOOKUP, 64'h41, $urandom);
        push_op(OP_INSERT, 64'h0140, 32'h0000_0140);
        push_op(OP_INSERT, 64'h41, 32'h0000_0041);
        push_op(OP_LOOKUP, 64'h41, $urandom);
        push_op(OP_DELETE, 64'h0140, $urandom);
        push_op(OP_LOOKUP, 64'h41, $urandom);
        push_op(OP_INSERT, 64'h41, 32'h8000_0000);
        push_op(OP_INSERT, 64'h3f, 32'h3f);
        push_op(OP_INSERT, 64'h7f, 32'h7f);
        push_op(OP_INSERT, 64'hbf, 32'hbf);
        push_op(OP_LOOKUP, 64'hbf, $urandom);
        push_op(OP_DELETE, 64'h7f, $urandom);
        push_op(OP_LOOKUP, 64'hbf, $urandom);
        wait_drained();

        // mixed traffic, idling switched off every third stretch
        repeat (200) begin
            tx_idle_pct = ((ops_sent / 50) % 3 == 2) ? 0 : 25;
            rx_idle_pct = tx_idle_pct;
            random_op();
        end

        // receiver holds off while transactions keep coming
        hold_req = 1'b1;
        repeat (12) random_op();
        wait_drained();

        // fill to capacity, then probe a full table
        for (int n = 0; n < 120 && mirror.live < SLOTS; n++) begin
            fresh = scatter_key();
            fill_keys.push_back(fresh);
            push_op(OP_INSERT, fresh, $urandom);
        end
        repeat (4) push_op(OP_INSERT, scatter_key(), $urandom);
        repeat (4) push_op(OP_LOOKUP, scatter_key(), $urandom);
        repeat (6) push_op(OP_LOOKUP, fill_keys[$urandom_range(0, fill_keys.size() - 1)],
                           $urandom);
        foreach (fill_keys[i]) begin
            push_op(OP_DELETE, fill_keys[i], $urandom);
        end
        // misses now walk long tombstone runs
        repeat (6) push_op(OP_LOOKUP, scatter_key(), $urandom);

        while (ops_sent < TARGET_OPS) begin
            if (ops_sent >= TARGET_OPS - QUIET_TAIL) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else begin
                tx_idle_pct = 25;
                rx_idle_pct = 25;
            end
            random_op();
        end

        wait_drained();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        $display("ran %0d table transactions, %0d replies checked", ops_sent, mirror.checked);
        $display("covered key aliasing, tombstone runs, wrap-around, a full table and stalls");
        if (mirror.errors == 0 && mirror.pending() == 0) begin
            $display("linear_probe_hash_table_test: clean");
        end else begin
            $display("linear_probe_hash_table_test: errors");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/lpht_pkg.sv
sv/lpht_ram.sv
sv/lpht_ctrl.sv
sv/lpht_dp.sv
sv/linear_probe_hash_table.sv
verif/hash_table_mirror_pkg.sv
verif/linear_probe_hash_table_test.sv
